@@ hw/rtl/cdd_pkg.sv @@
package cdd_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 22;
  // day numbers reach about 6.0e6 for the largest 14-bit year
  localparam int DayNumW = 23;

  localparam logic [DayNumW-1:0] DaysPerYear = 23'd365;

  // x / 25 for x below 4096 is (x * 1311) >> 15
  localparam logic [10:0] Recip25 = 11'd1311;
  localparam int RecipShift = 15;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } cdd_date_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic sel;
    logic finish;
  } cdd_cmd_t;

  // length of a month, zero for a month outside 1..12
  function automatic logic [4:0] month_days(input logic [MonthW-1:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m >= 4'd1 && m <= 4'd12) begin
      len = MonthLen[4'(m - 4'd1)];
      if (m == 4'd2 && leap) begin
        len = 5'd29;
      end
    end
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/cdd_ctrl.sv @@
module cdd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cdd_pkg::cdd_cmd_t cmd
);
  import cdd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_SUM0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_SUM1 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // command decode
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.mul    = (state == S_MUL0) || (state == S_MUL1);
    cmd.sum    = (state == S_SUM0) || (state == S_SUM1);
    cmd.sel    = (state == S_MUL1) || (state == S_SUM1);
    cmd.finish = (state == S_DONE) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        state_next = S_MUL0;
      end
      S_MUL0: state_next = S_SUM0;
      S_SUM0: state_next = S_MUL1;
      S_MUL1: state_next = S_SUM1;
      S_SUM1: state_next = S_DONE;
      S_DONE: if (cmd.finish) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/cdd_datapath.sv @@
module cdd_datapath (
  input  logic                        clk,
  input  cdd_pkg::cdd_cmd_t           cmd,
  input  cdd_pkg::cdd_date_t          in_start,
  input  cdd_pkg::cdd_date_t          in_end,
  output logic [cdd_pkg::CountW-1:0]  day_count,
  output logic                        bad_date
);
  import cdd_pkg::*;

  cdd_date_t start_r;
  cdd_date_t end_r;
  cdd_date_t cur;

  logic [DayNumW-1:0] y365;
  logic [22:0]        prod100;
  logic [20:0]        prod400;
  logic [22:0]        prod_yq;
  logic [DayNumW-1:0] day_a;
  logic [DayNumW-1:0] day_b;
  logic               valid_a;
  logic               valid_b;

  logic [YearW-1:0]   prev_year;
  logic [11:0]        q4;
  logic [9:0]         q16;
  logic [7:0]         div100;
  logic [5:0]         div400;
  logic [7:0]         hund;
  logic [11:0]        hund25;
  logic               leap;
  logic [4:0]         len;
  logic               valid;
  logic [12:0]        leap_days;
  logic [DayNumW-1:0] day_num;
  logic [DayNumW-1:0] diff;

  // shared unit works on the start date, then on the end date
  assign cur       = cmd.sel ? end_r : start_r;
  assign prev_year = cur.year - 14'd1;
  assign q4        = prev_year[13:2];
  assign q16       = prev_year[13:4];

  // quotients from the registered reciprocal products
  assign div100 = prod100[22:RecipShift];
  assign div400 = prod400[20:RecipShift];
  assign hund   = prod_yq[22:RecipShift];
  assign hund25 = 12'(hund) * 12'd25;

  // 4/100/400 rule: a multiple of 4 that is not a multiple of 100, or whose century is a multiple of 4
  assign leap = (cur.year[1:0] == 2'b00) &&
                ((cur.year[13:2] != hund25) || (hund[1:0] == 2'b00));

  // date check
  assign len   = month_days(cur.month, leap);
  assign valid = (len != 5'd0) && (cur.day != 5'd0) && (cur.day <= len);

  // leap days in the years before this one, plus year 0 itself
  assign leap_days = (cur.year != 14'd0) ?
                     (13'(q4) - 13'(div100) + 13'(div400) + 13'd1) : 13'd0;

  assign day_num = y365 + 23'(leap_days) + 23'(days_before(cur.month))
                 + 23'(leap && (cur.month > 4'd2)) + 23'(cur.day) - 23'd1;

  assign diff = day_b - day_a;

  always_ff @(posedge clk) begin
    // capture item
    if (cmd.load) begin
      start_r <= in_start;
      end_r   <= in_end;
    end
    // multiply stage
    if (cmd.mul) begin
      y365    <= 23'(cur.year) * DaysPerYear;
      prod100 <= 23'(q4) * 23'(Recip25);
      prod400 <= 21'(q16) * 21'(Recip25);
      prod_yq <= 23'(cur.year[13:2]) * 23'(Recip25);
    end
    // sum stage
    if (cmd.sum) begin
      if (cmd.sel) begin
        day_b   <= day_num;
        valid_b <= valid;
      end else begin
        day_a   <= day_num;
        valid_a <= valid;
      end
    end
    // result, saturated at the count width
    if (cmd.finish) begin
      bad_date <= !(valid_a && valid_b);
      if (valid_a && valid_b && (day_a < day_b)) begin
        day_count <= diff[22] ? {CountW{1'b1}} : diff[CountW-1:0];
      end else begin
        day_count <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/calendar_day_difference.sv @@
// Days between two proleptic Gregorian dates. Each item carries a start and an
// end date; the result is the number of days from start to end, zero when the
// start is not earlier, and bad_date with a zero count when either date has a
// month outside 1..12 or a day of 0 or past the month's length. A new item
// is accepted only after the previous one has left the compare step: one shared
// day-number unit runs a multiply step and a sum step for each of the two
// dates, then a compare and subtract step writes the output register. The next
// item is accepted while a result still waits in the output register; if that
// result is still waiting when the new item reaches the compare step, the block
// holds there until the result is taken.
module calendar_day_difference (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18],
  // end_year[36:23], end_month[40:37], end_day[45:41], zero[47:46]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // day_count[21:0], zero[23:22]
  output logic [23:0] m_axis_tdata,
  // bad_date[0]
  output logic [0:0]  m_axis_tuser
);
  import cdd_pkg::*;

  cdd_cmd_t           cmd;
  cdd_date_t          in_start;
  cdd_date_t          in_end;
  logic [CountW-1:0]  day_count;
  logic               bad_date;

  // unpack the input item
  assign in_start.year  = s_axis_tdata[13:0];
  assign in_start.month = s_axis_tdata[17:14];
  assign in_start.day   = s_axis_tdata[22:18];
  assign in_end.year    = s_axis_tdata[36:23];
  assign in_end.month   = s_axis_tdata[40:37];
  assign in_end.day     = s_axis_tdata[45:41];

  cdd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  cdd_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .in_start  (in_start),
    .in_end    (in_end),
    .day_count (day_count),
    .bad_date  (bad_date)
  );

  // pack the result item
  assign m_axis_tdata = {2'b00, day_count};
  assign m_axis_tuser = bad_date;

  // busy once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again right after an item was taken");

  // a bad date never carries a count
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[21:0] == 22'd0))
    else $error("bad date with nonzero day count");

  // a new result only comes out of a busy sequence
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

endmodule

@@ tb/sv/day_count_checker.sv @@
`timescale 1ns / 1ps

module day_count_checker
  import cdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18],
  // end_year[36:23], end_month[40:37], end_day[45:41], zero[47:46]
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // day_count[21:0], zero[23:22]
  input  logic [23:0] m_axis_tdata,
  // bad_date[0]
  input  logic [0:0]  m_axis_tuser,
  output int          fails,
  output int          pending,
  output int          checked
);

  localparam int unsigned CountCap = (1 << CountW) - 1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              bad;
  } span_t;

  span_t span_q[$];

  initial begin
    fails   = 0;
    pending = 0;
    checked = 0;
  end

  function automatic logic is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // zero for a month outside 1..12
  function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
    int unsigned len;
    case (mo)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(yr) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // days from 0000-01-01 to a valid date
  function automatic int unsigned day_index(input int unsigned yr, input int unsigned mo,
                                            input int unsigned dy);
    int unsigned n;
    int unsigned prev;
    n = 365 * yr;
    if (yr >= 1) begin
      prev = yr - 1;
      n += prev / 4 - prev / 100 + prev / 400 + 1;
    end
    for (int unsigned i = 1; i < mo; i++) begin
      n += month_length(i, yr);
    end
    return n + dy - 1;
  endfunction

  function automatic span_t predict_span(input logic [47:0] word);
    int unsigned sy, sm, sd, ey, em, ed;
    int unsigned a, b;
    span_t res;
    sy = word[13:0];
    sm = word[17:14];
    sd = word[22:18];
    ey = word[36:23];
    em = word[40:37];
    ed = word[45:41];
    res = '0;
    if (month_length(sm, sy) == 0 || sd == 0 || sd > month_length(sm, sy) ||
        month_length(em, ey) == 0 || ed == 0 || ed > month_length(em, ey)) begin
      res.bad = 1'b1;
    end else begin
      a = day_index(sy, sm, sd);
      b = day_index(ey, em, ed);
      if (a < b) begin
        res.count = (b - a > CountCap) ? CountCap[CountW-1:0] : CountW'(b - a);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
    fails++;
  endtask

  // compare results against the oldest prediction, then queue new predictions
  always @(posedge clk) begin
    span_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (span_q.size() == 0) begin
          report_mismatch("result with no item waiting, day_count", m_axis_tdata[CountW-1:0], 0);
        end else begin
          want = span_q.pop_front();
          checked++;
          if (m_axis_tdata[CountW-1:0] !== want.count) begin
            report_mismatch("day_count", m_axis_tdata[CountW-1:0], want.count);
          end
          if (m_axis_tuser[0] !== want.bad) begin
            report_mismatch("bad_date", m_axis_tuser[0], want.bad);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        span_q.push_back(predict_span(s_axis_tdata));
      end
      pending = span_q.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import cdd_pkg::*;

  localparam int RandomItems = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int sent = 0;
  int fails;
  int pending;
  int checked;

  calendar_day_difference dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  day_count_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fails         (fails),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #3_000_000;
    $display("calendar_day_difference: mismatch");
    $finish;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic logic [47:0] pack_pair(input int unsigned sy, sm, sd, ey, em, ed);
    return {2'b00, ed[DayW-1:0], em[MonthW-1:0], ey[YearW-1:0],
            sd[DayW-1:0], sm[MonthW-1:0], sy[YearW-1:0]};
  endfunction

  // mostly plausible date pairs, some spanning the full year field, some raw noise
  function automatic logic [47:0] random_pair();
    int unsigned sy, sm, sd, ey, em, ed;
    int unsigned kind;
    int unsigned tmp;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      return {2'b00, 46'($urandom) | (46'($urandom) << 32)};
    end
    sy = (kind >= 70) ? $urandom_range(16383) : $urandom_range(9999);
    sm = $urandom_range(1, 12);
    sd = ($urandom_range(7) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    case ($urandom_range(3))
      0:       ey = sy;
      1:       ey = (sy + $urandom_range(6) > 3) ? sy + $urandom_range(6) - 3 : sy;
      2:       ey = $urandom_range(9999);
      default: ey = $urandom_range(16383);
    endcase
    if (ey > 16383) begin
      ey = 16383;
    end
    em = ($urandom_range(3) == 0) ? sm : $urandom_range(1, 12);
    ed = ($urandom_range(7) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    // keep the reversed order common too
    if ($urandom_range(3) == 0) begin
      tmp = sy; sy = ey; ey = tmp;
      tmp = sm; sm = em; em = tmp;
      tmp = sd; sd = ed; ed = tmp;
    end
    return pack_pair(sy, sm, sd, ey, em, ed);
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_pair(input logic [47:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every queued result has come back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_idle_pct  = 21;
    sink_idle_pct = 60;

    // directed edge dates
    send_pair(pack_pair(0, 1, 1, 0, 1, 2));
    send_pair(pack_pair(0, 1, 1, 9999, 12, 31));
    send_pair(pack_pair(2024, 6, 15, 2024, 6, 15));
    send_pair(pack_pair(2024, 6, 16, 2024, 6, 15));
    send_pair(pack_pair(2020, 0, 10, 2021, 1, 1));
    send_pair(pack_pair(2020, 1, 10, 2021, 13, 1));
    send_pair(pack_pair(16383, 15, 31, 16383, 15, 31));
    send_pair(pack_pair(2020, 5, 0, 2021, 5, 1));
    send_pair(pack_pair(2020, 4, 31, 2021, 5, 1));
    send_pair(pack_pair(2000, 2, 29, 2000, 3, 1));
    send_pair(pack_pair(1900, 2, 29, 1900, 3, 1));
    send_pair(pack_pair(2004, 1, 1, 2004, 2, 29));
    send_pair(pack_pair(2001, 1, 1, 2001, 2, 29));
    send_pair(pack_pair(1900, 2, 28, 1900, 3, 1));
    send_pair(pack_pair(0, 2, 29, 0, 3, 1));
    send_pair(pack_pair(1999, 12, 31, 2000, 1, 1));
    send_pair(pack_pair(9999, 12, 31, 10000, 1, 1));
    send_pair(pack_pair(16383, 12, 31, 0, 1, 1));
    send_pair(pack_pair(0, 1, 1, 16383, 12, 31));
    send_pair(pack_pair(5000, 7, 31, 12000, 2, 29));
    wait_all_results();

    // random pairs under three idle profiles
    for (int k = 0; k < RandomItems; k++) begin
      if (k == RandomItems / 3) begin
        wait_all_results();
        src_idle_pct  = 60;
        sink_idle_pct = 21;
      end
      if (k == 2 * RandomItems / 3) begin
        wait_all_results();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      send_pair(random_pair());
    end

    wait_all_results();
    repeat (20) @(negedge clk);

    $display("sent %0d date pairs, checked %0d results", sent, checked);
    $display("covered edge dates, leap rules, bad months and days, saturation, three idle mixes");
    if (fails == 0 && pending == 0) begin
      $display("calendar_day_difference: match");
    end else begin
      $display("calendar_day_difference: mismatch");
    end
    $finish;
  end

endmodule
